[hdl/assert_macros.svh]
// Assertion macros for the RTL of the batcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/sotb_pkg.sv]
// Shared types, constants and a helper function of the size or timeout batcher.
package sotb_pkg;

    localparam int QUEUE_DEPTH    = 64;
    localparam int HANDLE_BITS    = 16;
    localparam int TIME_BITS      = 32;
    localparam int IDX_BITS       = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS       = $clog2(QUEUE_DEPTH + 1);
    localparam int BATCH_BITS     = 7;
    localparam int WAIT_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int OUT_COUNT_BITS = 7;
    localparam int CMP_BITS       = (TIME_BITS > WAIT_BITS) ? TIME_BITS : WAIT_BITS;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_DRAIN   = 2'd2,
        CMD_UNUSED  = 2'd3
    } command_t;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic CFG_BATCH_SIZE = 1'b0;
    localparam logic CFG_WAIT_TICKS = 1'b1;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] id;
        logic [TIME_BITS-1:0]   stamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Zero acts as one and anything above the queue depth acts as the depth.
    function automatic logic [CNT_BITS-1:0] effective_batch(input logic [BATCH_BITS-1:0] size);
        logic [CNT_BITS-1:0] eff;
        if (size == '0)
        begin
            eff = CNT_BITS'(1);
        end
        else if (int'(size) > QUEUE_DEPTH)
        begin
            eff = CNT_BITS'(QUEUE_DEPTH);
        end
        else
        begin
            eff = CNT_BITS'(size);
        end
        return eff;
    endfunction

endpackage

[hdl/sotb_cell.sv]
// One storage cell of the handle chain: loads a new entry or takes its right neighbor's.
module sotb_cell
    import sotb_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     load_data,
    input  entry_t     next_data,
    output entry_t     data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        priority if (ctrl.load)
        begin
            data_reg <= load_data;
        end
        else if (ctrl.shift)
        begin
            data_reg <= next_data;
        end
        else
        begin
            data_reg <= data_reg;
        end
    end

    assign data = data_reg;

endmodule

[hdl/size_or_timeout_batcher.sv]
// Top level of the size or timeout batcher: queue chain, drain chain and control.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   command   | start, busy          | command, request_id
//   result    | valid (strobe)       | batch_item, out_request_id, last_of_batch,
//             |                      | batch_ready, timed_out, waiting_count,
//             |                      | error_code
//   config    | cfg_wr_en            | cfg_index, cfg_data
//
// Enqueue, tick and an empty drain make the update at accept and register the status result in
// S_REPORT; it is shown in the cycle in which busy drops again.
// A drain of n handles passes from the accept through S_MOVE, which moves n handles out of the
// head cell of the queue chain into the drain chain, and then S_EMIT, which delivers one handle
// per cycle.
// Reset clears control state only; the cells hold no reset and need no clearing pass.
// The receiver cannot stall; a result is on the ports for exactly one cycle.
`include "assert_macros.svh"

module size_or_timeout_batcher
    import sotb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic [HANDLE_BITS-1:0]    request_id,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      valid,
    output logic                      batch_item,
    output logic [HANDLE_BITS-1:0]    out_request_id,
    output logic                      last_of_batch,
    output logic                      batch_ready,
    output logic                      timed_out,
    output logic [OUT_COUNT_BITS-1:0] waiting_count,
    output logic [1:0]                error_code
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPORT,
        S_MOVE,
        S_EMIT
    } state_t;

    state_t                   state_reg;
    logic [CNT_BITS-1:0]      count_reg;
    logic [TIME_BITS-1:0]     tick_reg;
    logic [BATCH_BITS-1:0]    batch_size_reg;
    logic [WAIT_BITS-1:0]     wait_ticks_reg;
    logic [1:0]               err_reg;
    logic [CNT_BITS-1:0]      n_reg;
    logic [IDX_BITS-1:0]      k_reg;
    logic [CNT_BITS-1:0]      rem_reg;

    logic                     valid_reg;
    logic                     batch_item_reg;
    logic [HANDLE_BITS-1:0]   out_id_reg;
    logic                     last_reg;
    logic                     ready_reg;
    logic                     timed_out_reg;
    logic [CNT_BITS-1:0]      wcount_reg;
    logic [1:0]               err_out_reg;

    entry_t                   main_q   [QUEUE_DEPTH];
    cell_ctrl_t               main_ctl [QUEUE_DEPTH];
    entry_t                   drain_q   [QUEUE_DEPTH];
    cell_ctrl_t               drain_ctl [QUEUE_DEPTH];

    logic                     accept;
    logic                     enq_write;
    logic [CNT_BITS-1:0]      eff_batch;
    logic [TIME_BITS-1:0]     age;
    logic                     status_timed_out;
    logic                     status_ready;
    entry_t                   enq_entry;
    entry_t                   drain_entry;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign enq_write = accept && (command_t'(command) == CMD_ENQUEUE)
                       && (count_reg < CNT_BITS'(QUEUE_DEPTH));
    assign eff_batch = effective_batch(batch_size_reg);

    // Status always looks at the head cell and the count as they stand now.
    assign age              = tick_reg - main_q[0].stamp;
    assign status_timed_out = (count_reg != '0)
                              && (CMP_BITS'(age) >= CMP_BITS'(wait_ticks_reg));
    assign status_ready     = (count_reg != '0)
                              && ((count_reg >= eff_batch) || status_timed_out);

    assign enq_entry   = '{id: request_id, stamp: tick_reg};
    assign drain_entry = '{id: main_q[0].id, stamp: '0};

    // The queue chain holds waiting entries oldest first; a new entry lands in the
    // first free cell and a drain step moves every cell one place toward the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_main
        entry_t next_main;
        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign next_main = main_q[i];
        end
        else
        begin : g_mid
            assign next_main = main_q[i + 1];
        end
        assign main_ctl[i].load  = enq_write && (count_reg == CNT_BITS'(i));
        assign main_ctl[i].shift = (state_reg == S_MOVE);

        sotb_cell u_main_cell (
            .clk       (clk),
            .ctrl      (main_ctl[i]),
            .load_data (enq_entry),
            .next_data (next_main),
            .data      (main_q[i])
        );
    end

    // The drain chain collects the handles of one batch in order and then shifts
    // them out of its head cell, one per cycle.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_drain
        entry_t next_drain;
        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign next_drain = drain_q[i];
        end
        else
        begin : g_mid
            assign next_drain = drain_q[i + 1];
        end
        assign drain_ctl[i].load  = (state_reg == S_MOVE) && (k_reg == IDX_BITS'(i));
        assign drain_ctl[i].shift = (state_reg == S_EMIT);

        sotb_cell u_drain_cell (
            .clk       (clk),
            .ctrl      (drain_ctl[i]),
            .load_data (drain_entry),
            .next_data (next_drain),
            .data      (drain_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            tick_reg       <= '0;
            batch_size_reg <= BATCH_BITS'(8);
            wait_ticks_reg <= WAIT_BITS'(10);
            err_reg        <= ERR_OK;
            n_reg          <= '0;
            k_reg          <= '0;
            rem_reg        <= '0;
            valid_reg      <= 1'b0;
            batch_item_reg <= 1'b0;
            out_id_reg     <= '0;
            last_reg       <= 1'b0;
            ready_reg      <= 1'b0;
            timed_out_reg  <= 1'b0;
            wcount_reg     <= '0;
            err_out_reg    <= ERR_OK;
        end
        else
        begin
            valid_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_BATCH_SIZE: batch_size_reg <= cfg_data[BATCH_BITS-1:0];
                    CFG_WAIT_TICKS: wait_ticks_reg <= cfg_data[WAIT_BITS-1:0];
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (command_t'(command))
                            CMD_ENQUEUE:
                            begin
                                if (enq_write)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    err_reg   <= ERR_OK;
                                end
                                else
                                begin
                                    err_reg <= ERR_FULL;
                                end
                                state_reg <= S_REPORT;
                            end
                            CMD_TICK:
                            begin
                                tick_reg  <= tick_reg + 1'b1;
                                err_reg   <= ERR_OK;
                                state_reg <= S_REPORT;
                            end
                            CMD_DRAIN:
                            begin
                                if (count_reg == '0)
                                begin
                                    err_reg   <= ERR_EMPTY;
                                    state_reg <= S_REPORT;
                                end
                                else
                                begin
                                    n_reg     <= (eff_batch < count_reg) ? eff_batch : count_reg;
                                    k_reg     <= '0;
                                    state_reg <= S_MOVE;
                                end
                            end
                            CMD_UNUSED:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_REPORT:
                begin
                    valid_reg      <= 1'b1;
                    batch_item_reg <= 1'b0;
                    out_id_reg     <= '0;
                    last_reg       <= 1'b0;
                    ready_reg      <= status_ready;
                    timed_out_reg  <= status_timed_out;
                    wcount_reg     <= count_reg;
                    err_out_reg    <= err_reg;
                    state_reg      <= S_IDLE;
                end
                S_MOVE:
                begin
                    count_reg <= count_reg - 1'b1;
                    k_reg     <= k_reg + 1'b1;
                    if (CNT_BITS'(k_reg) + CNT_BITS'(1) == n_reg)
                    begin
                        rem_reg   <= n_reg;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // The queue no longer changes here, so every handle carries the
                    // status as it stands after the whole drain.
                    valid_reg      <= 1'b1;
                    batch_item_reg <= 1'b1;
                    out_id_reg     <= drain_q[0].id;
                    last_reg       <= (rem_reg == CNT_BITS'(1));
                    ready_reg      <= status_ready;
                    timed_out_reg  <= status_timed_out;
                    wcount_reg     <= count_reg;
                    err_out_reg    <= ERR_OK;
                    rem_reg        <= rem_reg - 1'b1;
                    if (rem_reg == CNT_BITS'(1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign valid          = valid_reg;
    assign batch_item     = batch_item_reg;
    assign out_request_id = out_id_reg;
    assign last_of_batch  = last_reg;
    assign batch_ready    = ready_reg;
    assign timed_out      = timed_out_reg;
    assign waiting_count  = OUT_COUNT_BITS'(wcount_reg);
    assign error_code     = err_out_reg;

    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= CNT_BITS'(QUEUE_DEPTH),
                "queue count beyond depth")
    `ASSERT_CLK(a_item_no_error, clk, rst_n, (valid && batch_item) |-> (error_code == ERR_OK),
                "drained handle carries an error")
    `ASSERT_CLK(a_last_is_item, clk, rst_n, (valid && last_of_batch) |-> batch_item,
                "last mark on a status transaction")
    `ASSERT_CLK(a_emit_count_stable, clk, rst_n, (state_reg == S_EMIT) |=> $stable(count_reg),
                "queue count moved while a batch is delivered")
    `ASSERT_NEVER(a_move_empty, clk, rst_n, (state_reg == S_MOVE) && (count_reg == '0),
                  "drain step on an empty queue")

endmodule

[bench/size_or_timeout_batcher_tb.sv]
// Self-checking testbench of the size or timeout batcher with its own batch predictor.
module size_or_timeout_batcher_tb
    import sotb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      batch_item;
        logic [HANDLE_BITS-1:0]    handle;
        logic                      last;
        logic                      ready;
        logic                      timed_out;
        logic [OUT_COUNT_BITS-1:0] count;
        logic [1:0]                err;
    } batch_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                command = CMD_TICK;
    logic [HANDLE_BITS-1:0]    request_id = '0;
    logic                      cfg_wr_en = 1'b0;
    logic                      cfg_index = CFG_BATCH_SIZE;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      valid;
    logic                      batch_item;
    logic [HANDLE_BITS-1:0]    out_request_id;
    logic                      last_of_batch;
    logic                      batch_ready;
    logic                      timed_out;
    logic [OUT_COUNT_BITS-1:0] waiting_count;
    logic [1:0]                error_code;

    // Predictor state: the waiting handles with their stamps, the tick counter and the registers.
    logic [HANDLE_BITS-1:0] waiting_handles[$];
    logic [TIME_BITS-1:0]   waiting_stamps[$];
    logic [TIME_BITS-1:0]   tick_now;
    logic [BATCH_BITS-1:0]  batch_limit;
    logic [WAIT_BITS-1:0]   wait_limit;

    batch_result_t expected_results[$];
    batch_result_t seen_result;
    batch_result_t wanted_result;
    int            mismatch_count = 0;
    int            idle_pct = 0;

    size_or_timeout_batcher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .request_id     (request_id),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .valid          (valid),
        .batch_item     (batch_item),
        .out_request_id (out_request_id),
        .last_of_batch  (last_of_batch),
        .batch_ready    (batch_ready),
        .timed_out      (timed_out),
        .waiting_count  (waiting_count),
        .error_code     (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int batch_take();
        int n;
        n = int'(batch_limit);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > QUEUE_DEPTH)
        begin
            n = QUEUE_DEPTH;
        end
        return n;
    endfunction

    // Builds one result with the queue status as it stands after the whole transaction.
    function automatic batch_result_t queue_status(logic item, logic [HANDLE_BITS-1:0] handle,
                                                   logic last, logic [1:0] err);
        batch_result_t r;
        logic [TIME_BITS-1:0] age;
        r.batch_item = item;
        r.handle     = handle;
        r.last       = last;
        r.err        = err;
        r.count      = OUT_COUNT_BITS'(waiting_handles.size());
        r.timed_out  = 1'b0;
        if (waiting_handles.size() != 0)
        begin
            age = tick_now - waiting_stamps[0];
            r.timed_out = (age >= TIME_BITS'(wait_limit));
        end
        r.ready = (waiting_handles.size() != 0) &&
                  (waiting_handles.size() >= batch_take() || r.timed_out);
        return r;
    endfunction

    function automatic void predict_batcher(command_t cmd, logic [HANDLE_BITS-1:0] rid);
        logic [HANDLE_BITS-1:0] drained[$];
        int n;
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (waiting_handles.size() >= QUEUE_DEPTH)
                begin
                    expected_results.push_back(queue_status(1'b0, '0, 1'b0, ERR_FULL));
                end
                else
                begin
                    waiting_handles.push_back(rid);
                    waiting_stamps.push_back(tick_now);
                    expected_results.push_back(queue_status(1'b0, '0, 1'b0, ERR_OK));
                end
            end
            CMD_TICK:
            begin
                tick_now = tick_now + 1'b1;
                expected_results.push_back(queue_status(1'b0, '0, 1'b0, ERR_OK));
            end
            CMD_DRAIN:
            begin
                if (waiting_handles.size() == 0)
                begin
                    expected_results.push_back(queue_status(1'b0, '0, 1'b0, ERR_EMPTY));
                end
                else
                begin
                    n = batch_take();
                    if (n > waiting_handles.size())
                    begin
                        n = waiting_handles.size();
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        drained.push_back(waiting_handles.pop_front());
                        void'(waiting_stamps.pop_front());
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        expected_results.push_back(
                            queue_status(1'b1, drained[i], (i == n - 1), ERR_OK));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, batch_result_t want, batch_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected item=%b id=%h last=%b ready=%b to=%b count=%0d err=%0d",
                     want.batch_item, want.handle, want.last, want.ready, want.timed_out,
                     want.count, want.err);
            $display("  actual   item=%b id=%h last=%b ready=%b to=%b count=%0d err=%0d",
                     got.batch_item, got.handle, got.last, got.ready, got.timed_out,
                     got.count, got.err);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            seen_result = '{batch_item, out_request_id, last_of_batch, batch_ready,
                            timed_out, waiting_count, error_code};
            if (expected_results.size() == 0)
            begin
                note_mismatch("result with no transaction pending", '0, seen_result);
            end
            else
            begin
                wanted_result = expected_results.pop_front();
                if (seen_result !== wanted_result)
                begin
                    note_mismatch("result mismatch", wanted_result, seen_result);
                end
            end
        end
    end

    // Drives one transaction after a random idle gap and waits until it is accepted.
    task automatic send_cmd(input command_t cmd, input logic [HANDLE_BITS-1:0] rid);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        request_id <= rid;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_batcher(cmd, rid);
    endtask

    task automatic wait_until_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        // An unused command gives no result, so the block may still be at work.
        repeat (8) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BATCH_SIZE)
        begin
            batch_limit = data[BATCH_BITS-1:0];
        end
        else
        begin
            wait_limit = data[WAIT_BITS-1:0];
        end
    endtask

    task automatic test_reset_settings();
        send_cmd(CMD_DRAIN, 16'h1234);
        send_cmd(CMD_ENQUEUE, 16'h0000);
        send_cmd(CMD_ENQUEUE, 16'hFFFF);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_UNUSED, 16'hA5A5);
        send_cmd(CMD_DRAIN, 16'h0000);
        send_cmd(CMD_DRAIN, 16'hFFFF);
        send_cmd(CMD_ENQUEUE, 16'h5A5A);
        // The oldest entry times out once ten ticks have passed since it arrived.
        repeat (10) send_cmd(CMD_TICK, 16'hFFFF);
        send_cmd(CMD_TICK, 16'h0001);
        send_cmd(CMD_DRAIN, 16'h0000);
        wait_until_idle();
    endtask

    task automatic test_batch_size_limits();
        write_reg(CFG_BATCH_SIZE, 16'd0);
        write_reg(CFG_WAIT_TICKS, 16'd0);
        send_cmd(CMD_ENQUEUE, 16'h8001);
        send_cmd(CMD_ENQUEUE, 16'h7FFE);
        send_cmd(CMD_DRAIN, 16'h0000);
        send_cmd(CMD_DRAIN, 16'h0000);
        send_cmd(CMD_DRAIN, 16'h0000);
        wait_until_idle();
        write_reg(CFG_BATCH_SIZE, 16'd127);
        write_reg(CFG_WAIT_TICKS, 16'hFFFF);
        send_cmd(CMD_ENQUEUE, 16'h0F0F);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_DRAIN, 16'h0000);
        wait_until_idle();
    endtask

    task automatic test_full_queue();
        write_reg(CFG_BATCH_SIZE, 16'd64);
        repeat (QUEUE_DEPTH) send_cmd(CMD_ENQUEUE, 16'($urandom_range(16'hFFFF)));
        send_cmd(CMD_ENQUEUE, 16'hDEAD);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_DRAIN, 16'h0000);
        send_cmd(CMD_DRAIN, 16'h0000);
        wait_until_idle();
    endtask

    task automatic run_random_phase(input int pct, input int batch, input int ticks,
                                    input int count);
        int pick;
        wait_until_idle();
        write_reg(CFG_BATCH_SIZE, 16'(batch));
        write_reg(CFG_WAIT_TICKS, 16'(ticks));
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                send_cmd(CMD_ENQUEUE, 16'($urandom_range(16'hFFFF)));
            end
            else if (pick < 75)
            begin
                send_cmd(CMD_TICK, 16'($urandom_range(16'hFFFF)));
            end
            else if (pick < 95)
            begin
                send_cmd(CMD_DRAIN, 16'($urandom_range(16'hFFFF)));
            end
            else
            begin
                send_cmd(CMD_UNUSED, 16'($urandom_range(16'hFFFF)));
            end
            // Now and then hold the next transaction until every result is back.
            if (i == count / 2 || $urandom_range(99) < 3)
            begin
                wait_until_idle();
            end
        end
        idle_pct = 0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 4, 3, 16);
        run_random_phase(67, $urandom_range(1, 16), $urandom_range(0, 12), 16);
        run_random_phase(0, 64, 0, 16);
        run_random_phase(8, $urandom_range(1, 8), $urandom_range(1, 20), 16);
    endtask

    initial
    begin
        tick_now    = '0;
        batch_limit = BATCH_BITS'(8);
        wait_limit  = WAIT_BITS'(10);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_settings();
        test_batch_size_limits();
        test_full_queue();
        test_random_traffic();

        wait_until_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
